/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the bond constraint core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define DBC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define DBC_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/dbc_pkg.sv */
// Types, scratch slot map and microcode tables of the bond constraint core.
package dbc_pkg;

  // Scratch memory geometry
  localparam int SLOT_DEPTH  = 64;
  localparam int UCODE_DEPTH = 128;
  typedef logic [5:0] slot_t;
  typedef logic [6:0] pc_t;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TIME_STEP      = 2'd0;
  localparam cfg_idx_t REG_BOND_LENGTH_SQ = 2'd1;
  localparam cfg_idx_t REG_PAIR_MASS      = 2'd2;

  // Micro-operation codes (also the operation codes of the arithmetic unit)
  typedef enum logic [2:0] {
    UOP_ADD,
    UOP_SUB,
    UOP_MUL,
    UOP_DIV,
    UOP_TSTZ,
    UOP_END
  } uop_e;

  typedef struct packed {
    uop_e  op;
    slot_t a;
    slot_t b;
    slot_t d;
    logic  cond;   // skipped once the pair is flagged degenerate
  } uop_t;

  typedef struct packed {
    logic start;
    uop_e op;
  } alu_req_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_LOAD,
    SQ_FETCH,
    SQ_EXEC,
    SQ_WAIT,
    SQ_RD,
    SQ_CAP,
    SQ_SEND
  } seq_state_e;

  // Scratch slot map: per atom position, velocity, force, mass
  localparam int ATOM_STRIDE = 10;
  localparam int SL_P0   = 0;
  localparam int SL_V0   = 3;
  localparam int SL_F0   = 6;
  localparam int SL_M0   = 9;
  localparam int SL_P1   = 10;
  localparam int SL_V1   = 13;
  localparam int SL_F1   = 16;
  localparam int SL_M1   = 19;
  localparam int SL_DT   = 20;
  localparam int SL_BL   = 21;
  localparam int SL_PM   = 22;
  localparam int SL_HALF = 23;
  localparam int SL_KQ   = 24;
  localparam int SL_DT2  = 25;
  localparam int SL_C    = 26;
  localparam int SL_T0   = 27;
  localparam int SL_T1   = 28;
  localparam int SL_D1   = 29;
  localparam int SL_D2   = 32;
  localparam int SL_R12  = 35;
  localparam int SL_R22  = 36;
  localparam int SL_DEN  = 37;
  localparam int SL_LAM  = 38;
  localparam int SL_G    = 39;
  localparam int LOAD_LAST = SL_KQ;
  localparam int OUT_LAST  = 8;

  function automatic uop_t mk(uop_e op, int a, int b, int d, logic cond);
    uop_t u;
    u.op   = op;
    u.a    = slot_t'(a);
    u.b    = slot_t'(b);
    u.d    = slot_t'(d);
    u.cond = cond;
    return u;
  endfunction

  // Drift of both atoms followed by the bond-length correction
  function automatic uop_t ucode_drift(pc_t pc);
    uop_t t [UCODE_DEPTH];
    int   n;
    for (int i = 0; i < UCODE_DEPTH; i++) t[i] = mk(UOP_END, 0, 0, 0, 1'b0);
    n = 0;
    t[n] = mk(UOP_MUL, SL_DT, SL_DT, SL_DT2, 1'b0);    n = n + 1;
    t[n] = mk(UOP_MUL, SL_DT2, SL_HALF, SL_T0, 1'b0);  n = n + 1;
    t[n] = mk(UOP_MUL, SL_T0, SL_KQ, SL_C, 1'b0);      n = n + 1;
    for (int k = 0; k < 3; k++) begin
      t[n] = mk(UOP_SUB, SL_P1 + k, SL_P0 + k, SL_D1 + k, 1'b0); n = n + 1;
    end
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 3; k++) begin
        t[n] = mk(UOP_MUL, a*ATOM_STRIDE + SL_V0 + k, SL_DT, SL_T0, 1'b0); n = n + 1;
        t[n] = mk(UOP_ADD, a*ATOM_STRIDE + k, SL_T0, a*ATOM_STRIDE + k, 1'b0); n = n + 1;
        t[n] = mk(UOP_DIV, a*ATOM_STRIDE + SL_F0 + k, a*ATOM_STRIDE + SL_M0, SL_T1, 1'b0);
        n = n + 1;
        t[n] = mk(UOP_MUL, SL_T1, SL_C, SL_T1, 1'b0); n = n + 1;
        t[n] = mk(UOP_ADD, a*ATOM_STRIDE + k, SL_T1, a*ATOM_STRIDE + k, 1'b0); n = n + 1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      t[n] = mk(UOP_SUB, SL_P1 + k, SL_P0 + k, SL_D2 + k, 1'b0); n = n + 1;
    end
    t[n] = mk(UOP_MUL, SL_D1, SL_D2, SL_R12, 1'b0); n = n + 1;
    for (int k = 1; k < 3; k++) begin
      t[n] = mk(UOP_MUL, SL_D1 + k, SL_D2 + k, SL_T0, 1'b0); n = n + 1;
      t[n] = mk(UOP_ADD, SL_R12, SL_T0, SL_R12, 1'b0);       n = n + 1;
    end
    t[n] = mk(UOP_MUL, SL_D2, SL_D2, SL_R22, 1'b0); n = n + 1;
    for (int k = 1; k < 3; k++) begin
      t[n] = mk(UOP_MUL, SL_D2 + k, SL_D2 + k, SL_T0, 1'b0); n = n + 1;
      t[n] = mk(UOP_ADD, SL_R22, SL_T0, SL_R22, 1'b0);       n = n + 1;
    end
    t[n] = mk(UOP_ADD, SL_DT2, SL_DT2, SL_T0, 1'b0);  n = n + 1;
    t[n] = mk(UOP_MUL, SL_T0, SL_R12, SL_DEN, 1'b0);  n = n + 1;
    t[n] = mk(UOP_TSTZ, SL_DEN, SL_DEN, SL_DEN, 1'b0); n = n + 1;
    t[n] = mk(UOP_SUB, SL_R22, SL_BL, SL_T0, 1'b1);   n = n + 1;
    t[n] = mk(UOP_MUL, SL_PM, SL_T0, SL_T0, 1'b1);    n = n + 1;
    t[n] = mk(UOP_DIV, SL_T0, SL_DEN, SL_T0, 1'b1);   n = n + 1;
    t[n] = mk(UOP_DIV, SL_T0, SL_KQ, SL_LAM, 1'b1);   n = n + 1;
    for (int k = 0; k < 3; k++) begin
      t[n] = mk(UOP_MUL, SL_LAM, SL_D2 + k, SL_G, 1'b1);        n = n + 1;
      t[n] = mk(UOP_ADD, SL_F0 + k, SL_G, SL_F0 + k, 1'b1);     n = n + 1;
      t[n] = mk(UOP_SUB, SL_F1 + k, SL_G, SL_F1 + k, 1'b1);     n = n + 1;
      t[n] = mk(UOP_DIV, SL_G, SL_M0, SL_T0, 1'b1);             n = n + 1;
      t[n] = mk(UOP_MUL, SL_T0, SL_C, SL_T0, 1'b1);             n = n + 1;
      t[n] = mk(UOP_ADD, SL_P0 + k, SL_T0, SL_P0 + k, 1'b1);    n = n + 1;
      t[n] = mk(UOP_DIV, SL_G, SL_M1, SL_T0, 1'b1);             n = n + 1;
      t[n] = mk(UOP_MUL, SL_T0, SL_C, SL_T0, 1'b1);             n = n + 1;
      t[n] = mk(UOP_SUB, SL_P1 + k, SL_T0, SL_P1 + k, 1'b1);    n = n + 1;
    end
    return t[pc];
  endfunction

  // Velocity correction along the bond
  function automatic uop_t ucode_rattle(pc_t pc);
    uop_t t [UCODE_DEPTH];
    int   n;
    for (int i = 0; i < UCODE_DEPTH; i++) t[i] = mk(UOP_END, 0, 0, 0, 1'b0);
    n = 0;
    for (int k = 0; k < 3; k++) begin
      t[n] = mk(UOP_SUB, SL_V1 + k, SL_V0 + k, SL_D1 + k, 1'b0); n = n + 1;
      t[n] = mk(UOP_SUB, SL_P1 + k, SL_P0 + k, SL_D2 + k, 1'b0); n = n + 1;
    end
    t[n] = mk(UOP_MUL, SL_D1, SL_D2, SL_R12, 1'b0); n = n + 1;
    for (int k = 1; k < 3; k++) begin
      t[n] = mk(UOP_MUL, SL_D1 + k, SL_D2 + k, SL_T0, 1'b0); n = n + 1;
      t[n] = mk(UOP_ADD, SL_R12, SL_T0, SL_R12, 1'b0);       n = n + 1;
    end
    t[n] = mk(UOP_TSTZ, SL_R12, SL_R12, SL_R12, 1'b0); n = n + 1;
    t[n] = mk(UOP_TSTZ, SL_BL, SL_BL, SL_BL, 1'b0);    n = n + 1;
    t[n] = mk(UOP_MUL, SL_HALF, SL_R12, SL_T0, 1'b1);  n = n + 1;
    t[n] = mk(UOP_DIV, SL_T0, SL_BL, SL_LAM, 1'b1);    n = n + 1;
    for (int k = 0; k < 3; k++) begin
      t[n] = mk(UOP_MUL, SL_LAM, SL_D2 + k, SL_G, 1'b1);     n = n + 1;
      t[n] = mk(UOP_ADD, SL_V0 + k, SL_G, SL_V0 + k, 1'b1);  n = n + 1;
      t[n] = mk(UOP_SUB, SL_V1 + k, SL_G, SL_V1 + k, 1'b1);  n = n + 1;
    end
    return t[pc];
  endfunction

endpackage

/* hw/rtl/dbc_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
module dbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read two
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* hw/rtl/dbc_alu.sv */
// Shared saturating fixed-point unit: add, subtract, multiply, divide.
module dbc_alu
  import dbc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  alu_req_t                      req_i,
  input  logic signed [VALUE_WIDTH-1:0] a_i,
  input  logic signed [VALUE_WIDTH-1:0] b_i,
  output logic                          done_o,
  output logic signed [VALUE_WIDTH-1:0] res_o
);

  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int NW  = W + F;
  localparam int NCH = (W + 15) / 16;
  localparam int PW  = NCH * 16;
  localparam int MW  = (2 * W > NW) ? 2 * W : NW;
  localparam int CW  = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  uop_e          op_q;
  logic          neg_q;
  logic [2*W-1:0] acc_q;
  logic [W-1:0]   ma_q;
  logic [PW-1:0]  mb_q;
  logic [NW-1:0]  num_q, quo_q;
  logic [W-1:0]   rem_q;
  logic [W-1:0]   res_q;

  logic [W-1:0]   ua, ub;
  logic [W:0]     sum;
  logic [W-1:0]   addsub;
  logic [W+15:0]  pp;
  logic [W:0]     r2;
  logic           ge;

  function automatic logic [W-1:0] sat_mag(logic neg, logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [W-1:0]  r;
    lim = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
    r   = (m > lim) ? lim[W-1:0] : m[W-1:0];
    return neg ? (~r + W'(1)) : r;
  endfunction

  // Operand magnitudes and the saturated add or subtract
  always_comb begin
    ua  = a_i[W-1] ? (~a_i + W'(1)) : a_i;
    ub  = b_i[W-1] ? (~b_i + W'(1)) : b_i;
    sum = (req_i.op == UOP_SUB) ? ({a_i[W-1], a_i} - {b_i[W-1], b_i})
                                : ({a_i[W-1], a_i} + {b_i[W-1], b_i});
    if (sum[W] != sum[W-1]) begin
      addsub = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      addsub = sum[W-1:0];
    end
    pp = ma_q * mb_q[PW-1 -: 16];
    r2 = {rem_q, num_q[NW-1]};
    ge = (r2 >= {1'b0, ma_q});
  end

  // Sequence multiply chunks and divide bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= UOP_ADD;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q <= req_i.op;
        case (req_i.op)
          UOP_MUL: begin
            busy_q <= 1'b1;
            cnt_q  <= CW'(NCH);
          end
          UOP_DIV: begin
            if (ub == '0) begin
              done_q <= 1'b1;
            end else begin
              busy_q <= 1'b1;
              cnt_q  <= CW'(NW);
            end
          end
          default: begin
            done_q <= 1'b1;
          end
        endcase
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= a_i[W-1] ^ b_i[W-1];
      case (req_i.op)
        UOP_MUL: begin
          acc_q <= '0;
          ma_q  <= ua;
          mb_q  <= PW'(ub);
        end
        UOP_DIV: begin
          ma_q  <= ub;
          rem_q <= '0;
          num_q <= NW'({ua, {F{1'b0}}});
          res_q <= '0;
        end
        default: begin
          res_q <= addsub;
        end
      endcase
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        if (op_q == UOP_MUL) begin
          res_q <= sat_mag(neg_q, MW'(acc_q >> F));
        end else begin
          res_q <= sat_mag(neg_q, MW'(quo_q));
        end
      end else if (op_q == UOP_MUL) begin
        acc_q <= (acc_q << 16) + (2*W)'(pp);
        mb_q  <= mb_q << 16;
      end else begin
        rem_q <= ge ? W'(r2 - {1'b0, ma_q}) : r2[W-1:0];
        quo_q <= {quo_q[NW-2:0], ge};
        num_q <= num_q << 1;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* hw/rtl/diatomic_bond_constraint_integrator_core.sv */
// Top level of the diatomic bond constraint core: handshakes, sequencer, config.
//
// Usage: the two atoms of a molecule enter on the s_axis channel as two beats.
// The first beat is held and gives no result. The second beat's tuser picks
// the operation (0 drift plus bond-length correction, 1 velocity correction)
// and starts the sequencer, which loads both atoms into a 64-word scratch RAM
// and runs a microprogram over one shared add/sub/multiply/divide unit.
// Each micro-op is fetched and issued, then waits for the unit: add and subtract
// need no sequencing, multiply works through (VALUE_WIDTH+15)/16 chunks of 16 bits
// and divide through VALUE_WIDTH+FRAC_BITS quotient bits (the bit-serial divider
// sets the pace); a skipped op is only fetched. A pair's run starts after both
// atoms and the constants are loaded into the scratch RAM.
// Two result beats follow on m_axis, first atom then second (tlast high),
// each read from the scratch RAM one word at a time. The input is not ready while a
// pair is in flight; a stalled m_axis receiver simply holds the block.
// Reset drops any held first atom and restores the configuration defaults.
// Configuration is to be written over the APB port while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module diatomic_bond_constraint_integrator_core
  import dbc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 20,
  localparam int IW  = ((10 * VALUE_WIDTH - 1 + 7) / 8) * 8,
  localparam int OW  = ((9 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int PDW = (VALUE_WIDTH - 1 > 32) ? 64 : 32,
  localparam int ASL = (VALUE_WIDTH - 1 > 32) ? 3 : 2,
  localparam int PAW = ASL + 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, force_x, force_y, force_z,
  //        atom_mass, zero fill
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [IW-1:0]  s_axis_tdata_i,
  // tuser: op
  input  logic           s_axis_tuser_i,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  // tdata: new_pos_x/y/z, new_vel_x/y/z, new_force_x/y/z, zero fill
  output logic [OW-1:0]  m_axis_tdata_o,
  output logic           m_axis_tlast_o,
  // tuser: degenerate
  output logic           m_axis_tuser_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [PDW-1:0] pwdata,
  output logic [PDW-1:0] prdata,
  output logic           pready
);

  localparam int W = VALUE_WIDTH;
  localparam logic [63:0] KQ_L   = ((64'd4184 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] HALF_L = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] DT_RST = 64'd1 << FRAC_BITS;
  localparam logic [63:0] BL_RST = ((64'd1205604 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] PM_RST = 64'd28 << FRAC_BITS;

  // Configuration registers
  logic [W-2:0] time_step_q, bond_length_sq_q, pair_mass_q;
  cfg_idx_t     cfg_idx;
  logic         cfg_we;

  // Held first atom and latched second atom
  logic [W-1:0] held_pvf_q [9];
  logic [W-2:0] held_mass_q;
  logic [W-1:0] cur_pvf_q [9];
  logic [W-2:0] cur_mass_q;
  logic         held_valid_q, held_valid_d;
  logic         op_q;

  // Sequencer
  seq_state_e   state_q, state_d;
  pc_t          pc_q, pc_d;
  logic [4:0]   cnt_q, cnt_d;
  logic [4:0]   cur_idx;
  logic         atom_q, atom_d;
  logic         degen_q, degen_d;
  uop_t         uop;
  logic         in_acc;

  // Scratch RAM and shared unit
  logic         ram_we;
  slot_t        ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [W-1:0] ram_wdata, rdata_a, rdata_b, load_val;
  alu_req_t     alu_req;
  logic         alu_done;
  logic signed [W-1:0] alu_res;

  logic [W-1:0] out_q [9];

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_t'(paddr[PAW-1:ASL]);
  assign cfg_we  = psel && penable && pwrite;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q      <= DT_RST[W-2:0];
      bond_length_sq_q <= BL_RST[W-2:0];
      pair_mass_q      <= PM_RST[W-2:0];
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TIME_STEP:      time_step_q      <= pwdata[W-2:0];
        REG_BOND_LENGTH_SQ: bond_length_sq_q <= pwdata[W-2:0];
        REG_PAIR_MASS:      pair_mass_q      <= pwdata[W-2:0];
        default: ;
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    case (cfg_idx)
      REG_TIME_STEP:      prdata = PDW'(time_step_q);
      REG_BOND_LENGTH_SQ: prdata = PDW'(bond_length_sq_q);
      REG_PAIR_MASS:      prdata = PDW'(pair_mass_q);
      default:            prdata = '0;
    endcase
  end

  // Capture atoms from the input beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!held_valid_q) begin
        for (int k = 0; k < 9; k++) held_pvf_q[k] <= s_axis_tdata_i[k*W +: W];
        held_mass_q <= s_axis_tdata_i[9*W +: W-1];
      end else begin
        for (int k = 0; k < 9; k++) cur_pvf_q[k] <= s_axis_tdata_i[k*W +: W];
        cur_mass_q <= s_axis_tdata_i[9*W +: W-1];
        op_q       <= s_axis_tuser_i;
      end
    end
  end

  // Value written to the scratch slot during the load sweep
  always_comb begin
    cur_idx = cnt_q - 5'(SL_P1);
    case (cnt_q) inside
      [0:8]:   load_val = held_pvf_q[cnt_q[3:0]];
      [10:18]: load_val = cur_pvf_q[cur_idx[3:0]];
      SL_M0:   load_val = W'(held_mass_q);
      SL_M1:   load_val = W'(cur_mass_q);
      SL_DT:   load_val = W'(time_step_q);
      SL_BL:   load_val = W'(bond_length_sq_q);
      SL_PM:   load_val = W'(pair_mass_q);
      SL_HALF: load_val = HALF_L[W-1:0];
      SL_KQ:   load_val = KQ_L[W-1:0];
      default: load_val = '0;
    endcase
  end

  assign uop = op_q ? ucode_rattle(pc_q) : ucode_drift(pc_q);

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SQ_IDLE;
      pc_q         <= '0;
      cnt_q        <= '0;
      atom_q       <= 1'b0;
      degen_q      <= 1'b0;
      held_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      pc_q         <= pc_d;
      cnt_q        <= cnt_d;
      atom_q       <= atom_d;
      degen_q      <= degen_d;
      held_valid_q <= held_valid_d;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_d         = state_q;
    pc_d            = pc_q;
    cnt_d           = cnt_q;
    atom_d          = atom_q;
    degen_d         = degen_q;
    held_valid_d    = held_valid_q;
    ram_we          = 1'b0;
    ram_waddr       = uop.d;
    ram_wdata       = alu_res;
    ram_raddr_a     = uop.a;
    ram_raddr_b     = uop.b;
    alu_req.start   = 1'b0;
    alu_req.op      = uop.op;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    case (state_q)
      SQ_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_acc) begin
          held_valid_d = !held_valid_q;
          if (held_valid_q) begin
            state_d = SQ_LOAD;
            cnt_d   = '0;
            degen_d = 1'b0;
          end
        end
      end
      SQ_LOAD: begin
        ram_we    = 1'b1;
        ram_waddr = slot_t'(cnt_q);
        ram_wdata = load_val;
        if (cnt_q == 5'(LOAD_LAST)) begin
          state_d = SQ_FETCH;
          pc_d    = '0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      SQ_FETCH: begin
        if (uop.op == UOP_END) begin
          state_d = SQ_RD;
          cnt_d   = '0;
          atom_d  = 1'b0;
        end else if (uop.cond && degen_q) begin
          pc_d = pc_q + pc_t'(1);
        end else begin
          state_d = SQ_EXEC;
        end
      end
      SQ_EXEC: begin
        if (uop.op == UOP_TSTZ) begin
          if (rdata_a == '0) degen_d = 1'b1;
          pc_d    = pc_q + pc_t'(1);
          state_d = SQ_FETCH;
        end else begin
          alu_req.start = 1'b1;
          state_d       = SQ_WAIT;
        end
      end
      SQ_WAIT: begin
        if (alu_done) begin
          ram_we  = 1'b1;
          pc_d    = pc_q + pc_t'(1);
          state_d = SQ_FETCH;
        end
      end
      SQ_RD: begin
        ram_raddr_a = slot_t'(atom_q ? ATOM_STRIDE : 0) + slot_t'(cnt_q);
        state_d     = SQ_CAP;
      end
      SQ_CAP: begin
        if (cnt_q == 5'(OUT_LAST)) begin
          state_d = SQ_SEND;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = SQ_RD;
        end
      end
      SQ_SEND: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          if (atom_q) begin
            state_d = SQ_IDLE;
          end else begin
            atom_d  = 1'b1;
            cnt_d   = '0;
            state_d = SQ_RD;
          end
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // Collect the result beat one word at a time
  always_ff @(posedge clk_i) begin
    if (state_q == SQ_CAP) begin
      out_q[cnt_q[3:0]] <= rdata_a;
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    for (int k = 0; k < 9; k++) m_axis_tdata_o[k*W +: W] = out_q[k];
  end
  assign m_axis_tlast_o = atom_q;
  assign m_axis_tuser_o = degen_q;

  dbc_ram #(
    .WIDTH (W),
    .DEPTH (SLOT_DEPTH)
  ) u_scratch (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  dbc_alu #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (rdata_a),
    .b_i    (rdata_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // Checks
  `DBC_NEVER(a_busy_both_sides, clk_i, rst_ni, s_axis_tready_o && m_axis_tvalid_o, "input ready while a result is pending")
  `DBC_ASSERT(a_pair_starts_load, clk_i, rst_ni, in_acc && held_valid_q |=> state_q == SQ_LOAD, "second atom did not start the load sweep")
  `DBC_ASSERT(a_last_to_idle, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> s_axis_tready_o, "block not ready after the last beat")
  `DBC_ASSERT(a_done_in_wait, clk_i, rst_ni, alu_done |-> state_q == SQ_WAIT, "arithmetic result arrived outside the wait state")

endmodule

/* verif/tb_diatomic_bond_constraint_integrator_core.sv */
// Self-checking testbench for the diatomic bond constraint core: stream stimulus, predictor, APB.
module tb_diatomic_bond_constraint_integrator_core
  import dbc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VMAX      = 64'sd2147483647;
  localparam longint KCONST    = ((64'sd4184 <<< 20) + 64'sd5000000) / 64'sd10000000;
  localparam longint HALF      = 64'sd1 <<< 19;
  localparam int     LIMIT     = 3000000;
  localparam int     SETTLE    = 1200;
  localparam int     LONG_HOLD = 3000;

  typedef struct packed {
    logic            op;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] frc;
    logic [30:0]     mass;
  } atom_t;

  typedef struct packed {
    logic [8:0][31:0] fld;   // pos x/y/z, vel x/y/z, force x/y/z
    logic             last;
    logic             degen;
  } atom_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [319:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [287:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic         m_axis_tuser_o;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  diatomic_bond_constraint_integrator_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o, .m_axis_tuser_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  atom_t        atom_queue[$];
  atom_result_t result_queue[$];

  // Shadow of the configuration and of the held first atom
  longint cfg_dt, cfg_bl, cfg_pm;
  atom_t  held_atom;
  bit     holding = 1'b0;

  int errs = 0, cycles = 0, n_drift = 0, n_rattle = 0, n_degen = 0, n_results = 0;
  bit burst = 1'b0, hold_req = 1'b0, hold_done = 1'b0;
  int tx_gap = 0, rx_gap = 0, hold_left = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, result_queue.size());
      $display("tb_diatomic_bond_constraint_integrator_core NOT OK");
      $finish;
    end
  end

  // Saturating fixed-point arithmetic, truncation toward zero
  function automatic longint clamp(bit neg, longint m);
    if (neg) return (m > VMAX + 1) ? -(VMAX + 1) : -m;
    return (m > VMAX) ? VMAX : m;
  endfunction

  function automatic longint sadd(longint a, longint b);
    return (a + b > VMAX) ? VMAX : (a + b < -VMAX - 1) ? -VMAX - 1 : a + b;
  endfunction

  function automatic longint ssub(longint a, longint b);
    return sadd(a, -b);
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp(p < 0, ((p < 0) ? -p : p) >> 20);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    longint un, ud;
    if (d == 0) return 0;
    un = ((n < 0) ? -n : n) << 20;
    ud = (d < 0) ? -d : d;
    return clamp((n < 0) != (d < 0), un / ud);
  endfunction

  function automatic longint dot(longint a[3], longint b[3]);
    return sadd(sadd(qmul(a[0], b[0]), qmul(a[1], b[1])), qmul(a[2], b[2]));
  endfunction

  // Predict both results of a pair once its second atom is taken
  task automatic predict_pair(atom_t in);
    longint p[2][3], v[2][3], f[2][3], m[2];
    longint d1[3], d2[3];
    longint dt2, coeff, r12, r22, den, lam, g;
    bit degen;
    atom_t a;
    atom_result_t r;
    if (!holding) begin
      held_atom = in;
      holding = 1'b1;
      return;
    end
    holding = 1'b0;
    degen = 1'b0;
    for (int s = 0; s < 2; s++) begin
      a = (s == 0) ? held_atom : in;
      for (int k = 0; k < 3; k++) begin
        p[s][k] = longint'($signed(a.pos[k]));
        v[s][k] = longint'($signed(a.vel[k]));
        f[s][k] = longint'($signed(a.frc[k]));
      end
      m[s] = longint'(a.mass);
    end
    if (in.op == 1'b0) begin
      n_drift++;
      dt2 = qmul(cfg_dt, cfg_dt);
      coeff = qmul(qmul(dt2, HALF), KCONST);
      for (int k = 0; k < 3; k++) d1[k] = ssub(p[1][k], p[0][k]);
      for (int s = 0; s < 2; s++)
        for (int k = 0; k < 3; k++)
          p[s][k] = sadd(sadd(p[s][k], qmul(v[s][k], cfg_dt)), qmul(qdiv(f[s][k], m[s]), coeff));
      for (int k = 0; k < 3; k++) d2[k] = ssub(p[1][k], p[0][k]);
      r12 = dot(d1, d2);
      r22 = dot(d2, d2);
      den = qmul(sadd(dt2, dt2), r12);
      if (den == 0) begin
        degen = 1'b1;
      end else begin
        lam = qdiv(qdiv(qmul(cfg_pm, ssub(r22, cfg_bl)), den), KCONST);
        for (int k = 0; k < 3; k++) begin
          g = qmul(lam, d2[k]);
          f[0][k] = sadd(f[0][k], g);
          f[1][k] = ssub(f[1][k], g);
          p[0][k] = sadd(p[0][k], qmul(qdiv(g, m[0]), coeff));
          p[1][k] = ssub(p[1][k], qmul(qdiv(g, m[1]), coeff));
        end
      end
    end else begin
      n_rattle++;
      for (int k = 0; k < 3; k++) begin
        d1[k] = ssub(v[1][k], v[0][k]);
        d2[k] = ssub(p[1][k], p[0][k]);
      end
      r12 = dot(d1, d2);
      if (r12 == 0 || cfg_bl == 0) begin
        degen = 1'b1;
      end else begin
        lam = qdiv(qmul(HALF, r12), cfg_bl);
        for (int k = 0; k < 3; k++) begin
          g = qmul(lam, d2[k]);
          v[0][k] = sadd(v[0][k], g);
          v[1][k] = ssub(v[1][k], g);
        end
      end
    end
    if (degen) n_degen++;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < 3; k++) begin
        r.fld[k]     = p[s][k][31:0];
        r.fld[3 + k] = v[s][k][31:0];
        r.fld[6 + k] = f[s][k][31:0];
      end
      r.last  = (s == 1);
      r.degen = degen;
      result_queue.push_back(r);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 200);
  endfunction

  // Input driver: present queued atoms, with random idle gaps between beats
  always @(posedge clk_i or negedge rst_ni) begin
    atom_t nxt;
    logic [319:0] d;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        nxt = atom_queue.pop_front();
        predict_pair(nxt);
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (atom_queue.size() > 0) begin
          nxt = atom_queue[0];
          d = '0;
          for (int k = 0; k < 3; k++) begin
            d[32*k +: 32]      = nxt.pos[k];
            d[96 + 32*k +: 32] = nxt.vel[k];
            d[192 + 32*k +: 32] = nxt.frc[k];
          end
          d[288 +: 31] = nxt.mass;
          s_axis_tdata_i  <= d;
          s_axis_tuser_i  <= nxt.op;
          s_axis_tvalid_i <= 1'b1;
          tx_gap = pick_gap();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each result beat, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    atom_result_t want;
    bit bad;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_results++;
        if (result_queue.size() == 0) begin
          errs++;
          if (errs <= 10) $display("result beat with nothing expected: %h", m_axis_tdata_o);
        end else begin
          want = result_queue.pop_front();
          bad = (want.last != m_axis_tlast_o) || (want.degen != m_axis_tuser_o);
          for (int i = 0; i < 9; i++)
            if (want.fld[i] != m_axis_tdata_o[32*i +: 32]) bad = 1'b1;
          if (bad) begin
            errs++;
            if (errs <= 10) begin
              $display("mismatch at cycle %0d: last %b/%b degen %b/%b (expected/actual)",
                       cycles, want.last, m_axis_tlast_o, want.degen, m_axis_tuser_o);
              for (int i = 0; i < 9; i++)
                if (want.fld[i] != m_axis_tdata_o[32*i +: 32])
                  $display("  field %0d: expected %h actual %h", i, want.fld[i],
                           m_axis_tdata_o[32*i +: 32]);
            end
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        rx_gap = pick_gap();
      end
    end
  end

  // Configuration write: setup beat then access beat
  task automatic reg_write(cfg_idx_t idx, logic [30:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {1'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TIME_STEP:      cfg_dt = longint'(val);
      REG_BOND_LENGTH_SQ: cfg_bl = longint'(val);
      REG_PAIR_MASS:      cfg_pm = longint'(val);
      default: ;
    endcase
  endtask

  task automatic configure(logic [30:0] dt, logic [30:0] bl, logic [30:0] pm);
    reg_write(REG_TIME_STEP, dt);
    reg_write(REG_BOND_LENGTH_SQ, bl);
    reg_write(REG_PAIR_MASS, pm);
  endtask

  // Hold the sender until every pair has come back and the core is idle
  task automatic drain();
    do @(posedge clk_i);
    while (atom_queue.size() != 0 || s_axis_tvalid_i || result_queue.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic int sr(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic atom_t plain_atom();
    atom_t a;
    a.op = 1'($urandom_range(0, 1));
    for (int k = 0; k < 3; k++) begin
      a.pos[k] = sr(8 << 20);
      a.vel[k] = sr(1 << 16);
      a.frc[k] = sr(1 << 24);
    end
    a.mass = 31'($urandom_range(1 << 20, 40 << 20));
    return a;
  endfunction

  function automatic atom_t wild_atom();
    atom_t a;
    a.op = 1'($urandom_range(0, 1));
    for (int k = 0; k < 3; k++) begin
      a.pos[k] = $urandom;
      a.vel[k] = $urandom;
      a.frc[k] = $urandom;
    end
    a.mass = 31'($urandom);
    if (a.mass == 0) a.mass = 31'd1;
    return a;
  endfunction

  function automatic atom_t fill_atom(logic [31:0] val, logic [30:0] m, logic op);
    atom_t a;
    a.op = op;
    for (int k = 0; k < 3; k++) begin
      a.pos[k] = val;
      a.vel[k] = val;
      a.frc[k] = val;
    end
    a.mass = m;
    return a;
  endfunction

  task automatic add_pair(atom_t a, atom_t b);
    atom_queue.push_back(a);
    atom_queue.push_back(b);
  endtask

  // Random molecule: mostly a bonded pair, some noise and some collapsed pairs
  task automatic add_random_pair();
    atom_t a, b;
    int r;
    r = $urandom_range(0, 99);
    a = plain_atom();
    b = plain_atom();
    if (r < 70) begin
      for (int k = 0; k < 3; k++) b.pos[k] = a.pos[k] + sr(1 << 20);
    end else if (r < 85) begin
      a = wild_atom();
      b = wild_atom();
    end else if (r < 95) begin
      b.pos = a.pos;
      if (r < 90) b.vel = a.vel;
    end else begin
      for (int k = 0; k < 3; k++) b.pos[k] = a.pos[k] + sr(4);
    end
    add_pair(a, b);
  endtask

  initial begin
    atom_t a, b;
    cfg_dt = 1048576;
    cfg_bl = 1264167;
    cfg_pm = 29360128;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    configure(31'd1048576, 31'd1264167, 31'd29360128);

    // Directed: bonded pairs, collapsed pairs, field extremes, ignored first op
    a = plain_atom(); b = a;
    for (int k = 0; k < 3; k++) b.pos[k] = a.pos[k] + sr(1 << 20);
    b.op = 1'b0; add_pair(a, b);
    b.op = 1'b1; add_pair(a, b);
    a.op = 1'b1; b.op = 1'b0; add_pair(a, b);
    b = a; b.op = 1'b0; add_pair(a, b);
    b.op = 1'b1; add_pair(a, b);
    for (int op = 0; op < 2; op++) begin
      add_pair(fill_atom(32'h7FFFFFFF, 31'h7FFFFFFF, 1'b0),
               fill_atom(32'h80000000, 31'd1, op[0]));
      add_pair(fill_atom(32'h80000000, 31'd1, 1'b1),
               fill_atom(32'h7FFFFFFF, 31'h7FFFFFFF, op[0]));
      add_pair(fill_atom(32'h0, 31'd1, 1'b0), fill_atom(32'h00000001, 31'd1, op[0]));
    end
    drain();

    // Configuration extremes
    configure(31'd0, 31'd0, 31'd0);
    for (int i = 0; i < 4; i++) begin
      a = plain_atom(); b = plain_atom(); b.op = i[0]; add_pair(a, b);
    end
    drain();
    configure(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    for (int i = 0; i < 4; i++) begin
      a = plain_atom(); b = plain_atom(); b.op = i[0]; add_pair(a, b);
    end
    drain();

    // Random phases with varied settings; one without idling, one with a long stall
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 3) configure(31'($urandom), 31'($urandom), 31'($urandom));
      else configure(31'($urandom_range(1 << 18, 1 << 22)),
                     31'($urandom_range(1 << 19, 1 << 22)),
                     31'($urandom_range(1 << 20, 60 << 20)));
      burst = (ph == 1);
      for (int i = 0; i < 52; i++) add_random_pair();
      if (ph == 2) hold_req = 1'b1;
      drain();
    end
    burst = 1'b0;

    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d drift pairs and %0d velocity pairs, %0d flagged degenerate",
             n_drift, n_rattle, n_degen);
    $display("%0d result beats checked, %0d mismatches, %0d cycles", n_results, errs, cycles);
    if (errs == 0 && result_queue.size() == 0)
      $display("tb_diatomic_bond_constraint_integrator_core OK");
    else
      $display("tb_diatomic_bond_constraint_integrator_core NOT OK");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dbc_pkg.sv
hw/rtl/dbc_ram.sv
hw/rtl/dbc_alu.sv
hw/rtl/diatomic_bond_constraint_integrator_core.sv
verif/tb_diatomic_bond_constraint_integrator_core.sv
